### src/depth_frame_pseudocolor_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the depth pseudocolour block
// Shared property shapes, clocked and gated by a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef DEPTH_FRAME_PSEUDOCOLOR_TOP_DEFINES_SVH
`define DEPTH_FRAME_PSEUDOCOLOR_TOP_DEFINES_SVH

// same-cycle implication
`define DFPC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DFPC_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/dfpc_pkg.sv
// ---------------------------------------------------------------------------
// dfpc_pkg
// Constants and shared types for the depth pseudocolour block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfpc_pkg;

  // frame store geometry
  localparam int MaxPixels = 524288;
  localparam int AddrBits  = $clog2(MaxPixels);
  localparam int FillBits  = AddrBits + 1;

  // field widths
  localparam int DepthBits = 16;
  localparam int InBits    = 16;
  localparam int CfgBits   = 20;
  localparam int ColBits   = 8;
  localparam int ColMax    = (1 << ColBits) - 1;
  localparam int NumBits   = DepthBits + ColBits;
  localparam int OutBits   = 3 * ColBits;
  localparam int StepBits  = $clog2(ColBits);

  localparam int FrameReset = 307200;

  // divider request: numerator 255*d, divisor frame maximum
  typedef struct packed {
    logic                 start;
    logic [NumBits-1:0]   num;
    logic [DepthBits-1:0] den;
  } div_req_t;

  // divider response: one-cycle done pulse with quotient and remainder flag
  typedef struct packed {
    logic               done;
    logic [ColBits-1:0] quot;
    logic               rem_nz;
  } div_rsp_t;

endpackage

`default_nettype wire

### src/dfpc_ram.sv
// ---------------------------------------------------------------------------
// dfpc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfpc_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/dfpc_div.sv
// ---------------------------------------------------------------------------
// dfpc_div
// Restoring divider, one quotient bit a cycle, for an 8-bit quotient.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "depth_frame_pseudocolor_top_defines.svh"

module dfpc_div
  import dfpc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                busy;
  logic [StepBits-1:0] cnt;
  logic [NumBits-1:0]  rem;
  logic [NumBits-1:0]  dsr;
  logic [ColBits-1:0]  quot;
  logic                done;
  logic                ge;

  assign ge = (rem >= dsr);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= StepBits'(ColBits - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: divisor starts at den << (ColBits-1) and shifts right
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num;
      dsr  <= NumBits'(req.den) << (ColBits - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsr;
      end
      quot <= {quot[ColBits-2:0], ge};
      dsr  <= dsr >> 1;
    end
  end

  assign rsp.done   = done;
  assign rsp.quot   = quot;
  assign rsp.rem_nz = (rem != '0);

  `DFPC_ASSERT_NXT(a_start_busy, clk, rst, req.start, busy, "divider did not start")
  `DFPC_ASSERT_NXT(a_last_done, clk, rst, busy && (cnt == '0) && !req.start, done,
    "divider missed done")
  `DFPC_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "done while still busy")

endmodule

`default_nettype wire

### src/depth_frame_pseudocolor_top.sv
// ---------------------------------------------------------------------------
// depth_frame_pseudocolor_top
// Depth frame to pseudocolour, one frame late, scaled by the frame maximum.
// ---------------------------------------------------------------------------
// Each depth beat is stored at its index in the frame store, and the beat
// out is the colour of the pixel at that index in the previous frame: red =
// 255*d/max, blue = alpha = 255*(max-d)/max, zero depth gives alpha 255 only,
// a depth at or above max gives red 255. One pixel is in flight at a time:
// after the accept the frame store is read, in-range pixels then pass through
// the 8-step bit-serial divider, and the result is loaded into the output
// register once it is free; only then is the next pixel taken.
// The output register lets the next pixel be taken while a result waits.
// There is no clearing pass after reset: a fill count marks how far the store
// has been written, and entries beyond it read as zero.
`timescale 1ns / 1ps
`default_nettype none

`include "depth_frame_pseudocolor_top_defines.svh"

module depth_frame_pseudocolor_top
  import dfpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration: frame_pixels
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgBits-1:0] cfg_data,
  // depth in
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [InBits-1:0]  s_tdata,   // [15:0] depth_mm
  // colour out
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [OutBits-1:0]      m_tdata,   // [7:0] blue, [15:8] red, [23:16] alpha
  output logic                    m_tlast    // end_of_frame
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;

  logic [CfgBits-1:0]   last_idx;
  logic [AddrBits-1:0]  pixel_index;
  logic [DepthBits-1:0] running_max;
  logic [DepthBits-1:0] frame_max;
  logic [FillBits-1:0]  fill_cnt;

  logic [AddrBits-1:0]  idx_q;
  logic [DepthBits-1:0] d_q;
  logic [DepthBits-1:0] mx_q;
  logic                 eof_q;
  logic                 unwr_q;

  logic [ColBits-1:0]   res_blue;
  logic [ColBits-1:0]   res_red;
  logic [ColBits-1:0]   res_alpha;

  logic                 acc;
  logic                 eof_now;
  logic [DepthBits-1:0] d_in;
  logic [DepthBits-1:0] max_next;
  logic [DepthBits-1:0] rdata;
  logic [DepthBits-1:0] stored;
  logic                 out_free;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign acc       = s_tvalid && s_tready;
  assign d_in      = s_tdata[DepthBits-1:0];
  assign eof_now   = (CfgBits'(pixel_index) >= last_idx);
  assign max_next  = (d_in > running_max) ? d_in : running_max;
  assign stored    = unwr_q ? '0 : rdata;
  assign out_free  = !m_tvalid || m_tready;

  // frame size register, kept as the clamped last index
  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx <= CfgBits'(FrameReset - 1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data == '0) begin
        last_idx <= '0;
      end else if (int'(cfg_data) > MaxPixels) begin
        last_idx <= CfgBits'(MaxPixels - 1);
      end else begin
        last_idx <= cfg_data - 1'b1;
      end
    end
  end

  // frame tracking on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index <= '0;
      running_max <= '0;
      frame_max   <= '0;
    end else if (acc) begin
      if (eof_now) begin
        frame_max   <= max_next;
        running_max <= '0;
        pixel_index <= '0;
      end else begin
        running_max <= max_next;
        pixel_index <= pixel_index + 1'b1;
      end
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (acc) begin
      idx_q  <= pixel_index;
      d_q    <= d_in;
      mx_q   <= frame_max;
      eof_q  <= eof_now;
      unwr_q <= (FillBits'(pixel_index) >= fill_cnt);
    end
  end

  // fill count: writes run contiguously from index zero
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if ((state == ST_RD) && (FillBits'(idx_q) == fill_cnt)) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
  end

  // frame store: read on accept, write back the new depth in the cycle after, in ST_RD
  dfpc_ram #(
    .Width(DepthBits),
    .Depth(MaxPixels)
  ) u_store (
    .clk  (clk),
    .we   (state == ST_RD),
    .waddr(idx_q),
    .wdata(d_q),
    .re   (acc),
    .raddr(pixel_index),
    .rdata(rdata)
  );

  // divider start for the in-range case
  always_comb begin
    div_req.start = (state == ST_RD) && (stored != '0) && (stored < mx_q);
    div_req.num   = (NumBits'(stored) << ColBits) - NumBits'(stored);
    div_req.den   = mx_q;
  end

  dfpc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= div_req.start ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // colour result
  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      if (stored == '0) begin
        res_blue  <= '0;
        res_red   <= '0;
        res_alpha <= ColBits'(ColMax);
      end else begin
        // saturated case; overwritten by the divider otherwise
        res_blue  <= '0;
        res_red   <= ColBits'(ColMax);
        res_alpha <= '0;
      end
    end else if ((state == ST_DIV) && div_rsp.done) begin
      // floor(255 - x) = 255 - ceil(x)
      res_red   <= div_rsp.quot;
      res_blue  <= ColBits'(ColMax) - div_rsp.quot - ColBits'(div_rsp.rem_nz);
      res_alpha <= ColBits'(ColMax) - div_rsp.quot - ColBits'(div_rsp.rem_nz);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      m_tdata <= {res_alpha, res_red, res_blue};
      m_tlast <= eof_q;
    end
  end

  `DFPC_ASSERT_NXT(a_acc_rd, clk, rst, acc, state == ST_RD, "accept did not start a read")
  `DFPC_ASSERT_NXT(a_eof_wrap, clk, rst, acc && eof_now,
    (pixel_index == '0) && (running_max == '0), "frame end did not wrap")
  `DFPC_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill_cnt <= FillBits'(MaxPixels),
    "fill count beyond store depth")
  `DFPC_ASSERT_IMP(a_div_state, clk, rst, div_rsp.done, state == ST_DIV,
    "divider result outside divide state")

endmodule

`default_nettype wire
